>>> rtl/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 11;
  localparam int OP_W    = 3;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_QUERY      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    word_t           data_in;
  } in_word_t;

  typedef struct packed {
    word_t              popped_value;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic               empty_flag;
    word_t              front_value;
    word_t              back_value;
  } out_word_t;

endpackage

>>> rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// Double-ended queue of signed words held in a ring buffer of DEPTH entries.
// Input channel (in_valid, in_stall, in_word): one word carries an op code
// (push front, push back, pop front, pop back, query) and the data to push.
// Output channel (out_valid, out_stall, out_word): one result per input word,
// with the popped word, a status (ok, pop on empty, push dropped when full),
// and the count, empty flag, front and back words after the operation.
// Each result passes the core stage register and then the output register
// after its input word is accepted.
// Throughput: one word per cycle while in_stall is low. The front and back
// words are cached in registers; after a pop the new end word comes from the
// single read port of the ring memory, in the cycle after the pop.
// Reset (rst, synchronous): the queue becomes empty, no result is pending.
// The memory is not cleared; only written entries are ever read.
// When out_stall holds a result, one more word is staged behind it and then
// in_stall rises until the output drains.
module double_ended_queue #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  dq_pkg::in_word_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output dq_pkg::out_word_t out_word
);

  logic              accept, advance, s1_valid;
  dq_pkg::out_word_t res;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  dq_core #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .word    (in_word),
    .advance (advance),
    .s1_valid(s1_valid),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= res;
    end
  end

endmodule

>>> rtl/dq_ram.sv
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dq_core.sv
`timescale 1ns / 1ps

module dq_core #(
  parameter int DEPTH      = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  dq_pkg::in_word_t word,
  input  logic             advance,
  output logic             s1_valid,
  output dq_pkg::out_word_t res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]         head, head_next, tail, tail_next;
  logic [CW-1:0]         occ, occ_next;
  logic [DATA_WIDTH-1:0] front_reg, front_next, back_reg, back_next;
  logic [DATA_WIDTH-1:0] front_cur, back_cur, d, popped, rdata;
  logic                  s1_rd_front, s1_rd_back, rd_front_next, rd_back_next;
  dq_pkg::out_word_t     s1_res;
  dq_pkg::status_e       status;
  logic                  full, empty;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;

  function automatic dq_pkg::word_t ext(input logic [DATA_WIDTH-1:0] w);
    ext = dq_pkg::word_t'($signed(w));
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    wrap_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(d),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);
  assign d         = DATA_WIDTH'(word.data_in);
  assign front_cur = (s1_valid && s1_rd_front) ? rdata : front_reg;
  assign back_cur  = (s1_valid && s1_rd_back) ? rdata : back_reg;
  assign re        = rd_front_next || rd_back_next;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    occ_next      = occ;
    front_next    = front_cur;
    back_next     = back_cur;
    popped        = '0;
    status        = dq_pkg::ST_OK;
    we            = 1'b0;
    waddr         = head;
    raddr         = head;
    rd_front_next = 1'b0;
    rd_back_next  = 1'b0;
    if (accept) begin
      unique case (dq_pkg::op_e'(word.op))
        dq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status = dq_pkg::ST_FULL;
          end else begin
            head_next  = wrap_dec(head);
            we         = 1'b1;
            waddr      = head_next;
            front_next = d;
            if (empty) begin
              back_next = d;
            end
            occ_next = occ + CW'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status = dq_pkg::ST_FULL;
          end else begin
            tail_next = wrap_inc(tail);
            we        = 1'b1;
            waddr     = tail_next;
            back_next = d;
            if (empty) begin
              front_next = d;
            end
            occ_next = occ + CW'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status = dq_pkg::ST_EMPTY;
          end else begin
            popped    = front_cur;
            head_next = wrap_inc(head);
            occ_next  = occ - CW'(1);
            if (occ == CW'(2)) begin
              front_next = back_cur;
            end else if (occ > CW'(2)) begin
              raddr         = head_next;
              rd_front_next = 1'b1;
            end
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status = dq_pkg::ST_EMPTY;
          end else begin
            popped    = back_cur;
            tail_next = wrap_dec(tail);
            occ_next  = occ - CW'(1);
            if (occ == CW'(2)) begin
              back_next = front_cur;
            end else if (occ > CW'(2)) begin
              raddr        = tail_next;
              rd_back_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head        <= '0;
      tail        <= AW'(DEPTH - 1);
      occ         <= '0;
      s1_valid    <= 1'b0;
      s1_rd_front <= 1'b0;
      s1_rd_back  <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      occ  <= occ_next;
      if (accept) begin
        s1_valid    <= 1'b1;
        s1_rd_front <= rd_front_next;
        s1_rd_back  <= rd_back_next;
      end else if (advance) begin
        s1_valid    <= 1'b0;
        s1_rd_front <= 1'b0;
        s1_rd_back  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_reg <= front_next;
    back_reg  <= back_next;
    if (accept) begin
      s1_res.popped_value <= ext(popped);
      s1_res.status       <= status;
      s1_res.count        <= dq_pkg::COUNT_W'(occ_next);
      s1_res.empty_flag   <= (occ_next == '0);
      s1_res.front_value  <= (occ_next == '0) ? '0 : ext(front_next);
      s1_res.back_value   <= (occ_next == '0) ? '0 : ext(back_next);
    end
  end

  always_comb begin
    res = s1_res;
    if (s1_rd_front) begin
      res.front_value = ext(rdata);
    end
    if (s1_rd_back) begin
      res.back_value = ext(rdata);
    end
  end

endmodule

>>> dv/tb_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_queue;

  localparam int DQ_DEPTH       = 1024;
  localparam int STALL_PCT      = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [dq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam dq_pkg::word_t WORD_MAX = 32'sh7fff_ffff;
  localparam dq_pkg::word_t WORD_MIN = 32'sh8000_0000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  dq_pkg::in_word_t  in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  dq_pkg::out_word_t out_word;

  dq_pkg::word_t     deque_words[$];
  dq_pkg::out_word_t result_q[$];
  int                mismatch_cnt = 0;
  int                idle_cycles  = 0;
  bit                quiet        = 1'b0;

  always #1 clk = ~clk;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  function automatic dq_pkg::out_word_t apply_deque_op(dq_pkg::in_word_t w);
    dq_pkg::out_word_t r;
    r = '0;
    r.status = dq_pkg::ST_OK;
    case (w.op)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (deque_words.size() >= DQ_DEPTH) r.status = dq_pkg::ST_FULL;
        else if (w.op == dq_pkg::OP_PUSH_FRONT) deque_words.insert(0, w.data_in);
        else deque_words.insert(deque_words.size(), w.data_in);
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (deque_words.size() == 0) begin
          r.status = dq_pkg::ST_EMPTY;
        end else if (w.op == dq_pkg::OP_POP_FRONT) begin
          r.popped_value = deque_words[0];
          deque_words.delete(0);
        end else begin
          r.popped_value = deque_words[$];
          deque_words.delete(deque_words.size() - 1);
        end
      end
      default: ;
    endcase
    r.count      = dq_pkg::COUNT_W'(deque_words.size());
    r.empty_flag = (deque_words.size() == 0);
    if (!r.empty_flag) begin
      r.front_value = deque_words[0];
      r.back_value  = deque_words[$];
    end
    return r;
  endfunction

  function automatic dq_pkg::word_t rand_word();
    case ($urandom_range(9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    dq_pkg::out_word_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected result word: pop %0d st %0d cnt %0d", out_word.popped_value,
                   out_word.status, out_word.count);
      end else begin
        exp_word = result_q[0];
        result_q.delete(0);
        if (out_word.popped_value !== exp_word.popped_value ||
            out_word.status       !== exp_word.status       ||
            out_word.count        !== exp_word.count        ||
            out_word.empty_flag   !== exp_word.empty_flag   ||
            out_word.front_value  !== exp_word.front_value  ||
            out_word.back_value   !== exp_word.back_value) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS) begin
            $display("mismatch: expected pop %0d st %0d cnt %0d emp %0b front %0d back %0d",
                     exp_word.popped_value, exp_word.status, exp_word.count,
                     exp_word.empty_flag, exp_word.front_value, exp_word.back_value);
            $display("          got      pop %0d st %0d cnt %0d emp %0b front %0d back %0d",
                     out_word.popped_value, out_word.status, out_word.count,
                     out_word.empty_flag, out_word.front_value, out_word.back_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(input logic [dq_pkg::OP_W-1:0] op, input dq_pkg::word_t data);
    dq_pkg::in_word_t w;
    w.op      = op;
    w.data_in = data;
    if (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    result_q.insert(result_q.size(), apply_deque_op(w));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_ops(input int n, input int push_pct, input int pop_pct);
    int                          r;
    logic [dq_pkg::OP_W-1:0]     op;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < push_pct)
        op = $urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT;
      else if (r < push_pct + pop_pct)
        op = $urandom_range(1) ? dq_pkg::OP_POP_BACK : dq_pkg::OP_POP_FRONT;
      else if ($urandom_range(1)) op = dq_pkg::OP_QUERY;
      else op = dq_pkg::OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      send_word(op, rand_word());
    end
  endtask

  task automatic test_empty_queue_edges();
    send_word(dq_pkg::OP_QUERY, '0);
    send_word(dq_pkg::OP_POP_FRONT, 32'sd5);
    send_word(dq_pkg::OP_POP_BACK, '1);
    send_word(dq_pkg::OP_PUSH_FRONT, WORD_MAX);
    send_word(dq_pkg::OP_PUSH_BACK, WORD_MIN);
    send_word(OP_UNUSED_LO, rand_word());
    send_word(OP_UNUSED_LO + 3'd1, rand_word());
    send_word(OP_UNUSED_HI, rand_word());
    send_word(dq_pkg::OP_PUSH_FRONT, '0);
    send_word(dq_pkg::OP_PUSH_BACK, '1);
    send_word(dq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    send_word(dq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa);
    send_word(dq_pkg::OP_QUERY, '1);
    repeat (3) send_word(dq_pkg::OP_POP_FRONT, rand_word());
    repeat (3) send_word(dq_pkg::OP_POP_BACK, rand_word());
    send_word(dq_pkg::OP_POP_BACK, rand_word());
    send_word(dq_pkg::OP_PUSH_BACK, rand_word());
    send_word(dq_pkg::OP_POP_FRONT, rand_word());
  endtask

  task automatic test_low_occupancy_random();
    send_random_ops(300, 40, 45);
  endtask

  task automatic test_fill_and_overflow();
    quiet = 1'b1;
    while (deque_words.size() < DQ_DEPTH) begin
      if (deque_words.size() >= DQ_DEPTH / 2) quiet = 1'b0;
      send_word($urandom_range(1) ? dq_pkg::OP_PUSH_BACK : dq_pkg::OP_PUSH_FRONT,
                rand_word());
    end
    quiet = 1'b0;
    wait_drained();
    send_word(dq_pkg::OP_PUSH_FRONT, WORD_MAX);
    send_word(dq_pkg::OP_PUSH_BACK, WORD_MIN);
    send_word(dq_pkg::OP_QUERY, rand_word());
    send_word(dq_pkg::OP_POP_FRONT, rand_word());
    send_word(dq_pkg::OP_PUSH_BACK, rand_word());
    send_word(dq_pkg::OP_PUSH_FRONT, rand_word());
    send_word(dq_pkg::OP_POP_BACK, rand_word());
  endtask

  task automatic test_near_full_random();
    send_random_ops(120, 50, 40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue_edges();
    test_low_occupancy_random();
    test_fill_and_overflow();
    test_near_full_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_cnt += result_q.size();
    if (mismatch_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
